// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Operation codes, status codes, field widths and controller commands.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEQ_DEPTH_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int FILL_W        = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_LEFT  = 2'd0,
        MODE_PUSH_RIGHT = 2'd1,
        MODE_POP_LEFT   = 2'd2,
        MODE_POP_RIGHT  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the accepted request
        logic exec;      // apply the operation to indices, count and storage
        logic load_out;  // move the result into the output register
    } t_deq_cmd;

endpackage

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: double-ended queue of signed 32-bit values
// Ring buffer of DEPTH entries; push/pop at either end, one result per request.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Payload
//  --------+---------------------------+--------------------------------------
//  in      | i_in_valid / o_in_ready   | i_mode, i_push_value
//  out     | o_out_valid / i_out_ready | o_pop_value, o_status, o_fill_count
//
//  A request passes through capture at the accepting edge, one memory
//  access (single read/write port, registered read), then load of the output
//  register. The next request is accepted as soon as the result is loaded,
//  even while that result still waits for i_out_ready; a full output
//  register stalls the load step. Synchronous active-low reset empties the
//  queue; entry storage is not cleared, since only written entries ever
//  reach the result.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic signed [DATA_W-1:0]   i_push_value,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [DATA_W-1:0]   o_pop_value,
    output logic [STATUS_W-1:0]        o_status,
    output logic [FILL_W-1:0]          o_fill_count
);

    t_deq_cmd cmd;

    // controller: sequencing and both handshakes
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // datapath: storage, end indices, count and result register
    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_fill_count (o_fill_count)
    );

endmodule

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl: sequencing controller
// Three one-hot states: wait for a request, execute it, hand off the result.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_deq_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/deq_dp.sv =====
// ----------------------------------------------------------------------------
// deq_dp: ring-buffer datapath
// Entry memory, left/right indices, entry count and the result register.
// ----------------------------------------------------------------------------
module deq_dp
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_deq_cmd            i_cmd,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [DATA_W-1:0]   i_push_value,
    output logic [DATA_W-1:0]   o_pop_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [FILL_W-1:0]   o_fill_count
);

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW_RAW = $clog2(DEPTH + 1);
    localparam int CW     = (CW_RAW > FILL_W) ? CW_RAW : FILL_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];

    t_mode             r_mode;
    logic [DATA_W-1:0] r_value;
    logic [AW-1:0]     r_left, n_left;
    logic [AW-1:0]     r_right, n_right;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_rd_data;
    t_status           r_res_status, n_res_status;
    logic [DATA_W-1:0] r_pop_value;
    t_status           r_status;
    logic [FILL_W-1:0] r_fill;

    logic [AW-1:0] left_dec, right_inc, right_dec;
    logic [AW-1:0] addr;
    logic          wr_en;
    logic          is_full, is_empty;

    assign left_dec  = (r_left == '0) ? LAST_IDX : r_left - 1'b1;
    assign right_inc = (r_right == LAST_IDX) ? '0 : r_right + 1'b1;
    assign right_dec = (r_right == '0) ? LAST_IDX : r_right - 1'b1;
    assign is_full   = (r_count == FULL_CNT);
    assign is_empty  = (r_count == '0);

    always_comb begin
        n_left       = r_left;
        n_right      = r_right;
        n_count      = r_count;
        n_res_status = ST_OK;
        wr_en        = 1'b0;
        addr         = r_left;
        case (r_mode)
            MODE_PUSH_LEFT: begin
                addr = left_dec;
                if (is_full) begin
                    n_res_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_left  = left_dec;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_PUSH_RIGHT: begin
                addr = r_right;
                if (is_full) begin
                    n_res_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_right = right_inc;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POP_LEFT: begin
                addr = r_left;
                if (is_empty) begin
                    n_res_status = ST_EMPTY;
                end else begin
                    n_left  = (r_left == LAST_IDX) ? '0 : r_left + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_POP_RIGHT: begin
                addr = right_dec;
                if (is_empty) begin
                    n_res_status = ST_EMPTY;
                end else begin
                    n_right = right_dec;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                addr = r_left;
            end
        endcase
    end

    // single-port memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (wr_en) begin
                mem[addr] <= r_value;
            end
            r_rd_data <= mem[addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode  <= t_mode'(i_mode);
            r_value <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_res_status <= n_res_status;
        end
        if (i_cmd.load_out) begin
            r_status <= r_res_status;
            r_fill   <= r_count[FILL_W-1:0];
            case (r_res_status)
                ST_OK: begin
                    if (r_mode == MODE_POP_LEFT || r_mode == MODE_POP_RIGHT) begin
                        r_pop_value <= r_rd_data;
                    end else begin
                        r_pop_value <= '0;
                    end
                end
                ST_EMPTY: r_pop_value <= '1;
                default:  r_pop_value <= '0;
            endcase
        end
    end

    assign o_pop_value  = r_pop_value;
    assign o_status     = r_status;
    assign o_fill_count = r_fill;

endmodule

// ===== verif/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker: request/result scoreboard for the double-ended queue
// Watches both channels, predicts each result from a private ring buffer and
// compares it field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module deq_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [DATA_W-1:0] i_pop_value,
    input  logic [STATUS_W-1:0]      i_status,
    input  logic [FILL_W-1:0]        i_fill_count,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0] pop_value;
        t_status                  status;
        logic [FILL_W-1:0]        fill_count;
    } t_deq_result;

    // private copy of the queue contents
    logic signed [DATA_W-1:0] model_store [DEPTH];
    int                       model_left;
    int                       model_right;
    int                       model_count;

    t_deq_result pending_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // applies one request to the private queue, returns the result it yields
    function automatic t_deq_result deque_apply(input t_mode op,
                                                input logic signed [DATA_W-1:0] value);
        t_deq_result res;
        res.pop_value = '0;
        res.status    = ST_OK;
        case (op)
            MODE_PUSH_LEFT, MODE_PUSH_RIGHT: begin
                if (model_count >= DEPTH) begin
                    res.status = ST_FULL;           // dropped, nothing moves
                end else if (op == MODE_PUSH_LEFT) begin
                    model_left = (model_left == 0) ? DEPTH - 1 : model_left - 1;
                    model_store[model_left] = value;
                    model_count++;
                end else begin
                    model_store[model_right] = value;
                    model_right = (model_right + 1) % DEPTH;
                    model_count++;
                end
            end
            default: begin
                if (model_count == 0) begin
                    res.status    = ST_EMPTY;
                    res.pop_value = -1;
                end else if (op == MODE_POP_LEFT) begin
                    res.pop_value = model_store[model_left];
                    model_left = (model_left + 1) % DEPTH;
                    model_count--;
                end else begin
                    model_right = (model_right == 0) ? DEPTH - 1 : model_right - 1;
                    res.pop_value = model_store[model_right];
                    model_count--;
                end
            end
        endcase
        res.fill_count = FILL_W'(model_count);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_deq_result exp_res;
        if (!i_rst_n) begin
            model_left  = 0;
            model_right = 0;
            model_count = 0;
            pending_results.delete();
            o_pending <= 0;
        end else begin
            // a result leaving now always belongs to an earlier request
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with no request waiting: value %0d",
                                              i_pop_value));
                end else begin
                    exp_res = pending_results.pop_front();
                    if (i_pop_value !== exp_res.pop_value)
                        report_mismatch($sformatf("pop_value expected %0d got %0d",
                                                  exp_res.pop_value, i_pop_value));
                    if (i_status !== exp_res.status)
                        report_mismatch($sformatf("status expected %s got %0d",
                                                  exp_res.status.name(), i_status));
                    if (i_fill_count !== exp_res.fill_count)
                        report_mismatch($sformatf("fill_count expected %0d got %0d",
                                                  exp_res.fill_count, i_fill_count));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_results.push_back(deque_apply(t_mode'(i_mode), i_push_value));
            o_pending <= pending_results.size();
        end
    end

endmodule

// ===== verif/double_ended_queue_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_tb: testbench top for the double-ended queue
// Drives push/pop requests, random back-pressure on the result side, and
// takes the verdict from the checker that sits beside the block.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import deq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = DEQ_DEPTH_DEF;
    localparam int SEG_ITEMS   = 225;   // 2 rounds x 4 idling phases -> 1800
    localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES = 20;    // slack before the final verdict

    // every input has a known value from time zero
    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic [MODE_W-1:0]        i_mode       = MODE_PUSH_LEFT;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic                     i_out_ready  = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_pop_value;
    logic [STATUS_W-1:0]      o_status;
    logic [FILL_W-1:0]        o_fill_count;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int gap_pct     = 0;   // chance the sender stays idle in a cycle
    int stall_pct   = 0;   // chance the receiver holds off in a cycle

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    double_ended_queue #(.DEPTH(DEPTH)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_fill_count (o_fill_count)
    );

    deq_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_pop_value  (o_pop_value),
        .i_status     (o_status),
        .i_fill_count (o_fill_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver back-pressure: a fresh coin each cycle. With stall_pct at 0
    // the result side is always ready.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one request and hold it until the block takes it. Valid stays
    // high on return so a back-to-back request needs no extra cycle.
    task automatic send_request(input t_mode op, input logic signed [DATA_W-1:0] value);
        i_in_valid   <= 1'b1;
        i_mode       <= op;
        i_push_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sender drops valid and stays quiet for the requested gap.
    task automatic sender_gap(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Sender holds off until every outstanding result is back. The first
    // edge lets the checker count the request accepted just before.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Push values lean on the extremes and the empty-pop marker so aliasing
    // with -1 or a sign slip shows up; the rest are small or full 32-bit randoms.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -1;
            3:       return 0;
            4:       return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // One idling phase of random traffic. Requests come in bursts that lean
    // toward pushes, toward pops, or neither, so the queue keeps running
    // into both the full and the empty boundary.
    task automatic random_segment(input int items);
        int   left_to_send;
        int   burst;
        int   push_pct;
        t_mode op;
        left_to_send = items;
        while (left_to_send > 0) begin
            burst = $urandom_range(8, 40);
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            while (burst > 0 && left_to_send > 0) begin
                if ($urandom_range(99) < push_pct)
                    op = t_mode'($urandom_range(1) ? MODE_PUSH_RIGHT : MODE_PUSH_LEFT);
                else
                    op = t_mode'($urandom_range(1) ? MODE_POP_RIGHT : MODE_POP_LEFT);
                send_request(op, pick_value());
                // one coin per cycle for the sender's idling
                while ($urandom_range(99) < gap_pct)
                    sender_gap(1);
                burst--;
                left_to_send--;
            end
        end
    endtask

    initial begin : stimulus
        int k;
        int round;
        int phase;

        // reset held from time zero, released once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed requests, no idling ---
        // pops on an empty queue from both ends
        send_request(MODE_POP_LEFT,  32'sh1234_5678);
        send_request(MODE_POP_RIGHT, 32'sh7FFF_FFFF);
        // extreme values in and back out, both ends
        send_request(MODE_PUSH_LEFT,  32'sh7FFF_FFFF);
        send_request(MODE_PUSH_RIGHT, 32'sh8000_0000);
        send_request(MODE_POP_LEFT,  0);
        send_request(MODE_POP_RIGHT, 0);
        // fill to DEPTH from alternating ends; left pushes wrap the left
        // index below zero on the first one
        for (k = 0; k < DEPTH; k++)
            send_request(t_mode'((k % 2) ? MODE_PUSH_RIGHT : MODE_PUSH_LEFT),
                         (k < 2) ? ((k == 0) ? -1 : 0) : $urandom);
        // pushes into a full queue at both ends are dropped
        send_request(MODE_PUSH_LEFT,  32'sh8000_0000);
        send_request(MODE_PUSH_RIGHT, 32'sh7FFF_FFFF);
        drain_results();

        // --- random traffic across idling phases ---
        for (round = 0; round < 2; round++) begin
            for (phase = 0; phase < 4; phase++) begin
                case (phase)
                    0: begin gap_pct = 0;  stall_pct = 0;  end
                    1: begin gap_pct = 45; stall_pct = 0;  end
                    2: begin gap_pct = 0;  stall_pct = 45; end
                    default: begin gap_pct = 33; stall_pct = 33; end
                endcase
                random_segment(SEG_ITEMS);
                // sender pauses until the block has answered everything
                drain_results();
            end
        end

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
